FILE: sv/plcs_pkg.sv
package plcs_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int NUM_LANES = 3;
    localparam int TDATA_W   = NUM_LANES * SAMPLE_W;

    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_KNEE_IN_LOW   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_KNEE_OUT_LOW  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_KNEE_IN_HIGH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_KNEE_OUT_HIGH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COLOUR_MODE   = 3'd4;

    localparam logic [SAMPLE_W-1:0] KNEE_IN_LOW_RST   = 8'd64;
    localparam logic [SAMPLE_W-1:0] KNEE_OUT_LOW_RST  = 8'd64;
    localparam logic [SAMPLE_W-1:0] KNEE_IN_HIGH_RST  = 8'd192;
    localparam logic [SAMPLE_W-1:0] KNEE_OUT_HIGH_RST = 8'd192;
    localparam logic                COLOUR_MODE_RST   = 1'b1;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 8'd255;

    // segments of the transfer curve
    localparam int SEG_CNT = 3;
    localparam logic [1:0] SEG_LOW  = 2'd0;
    localparam logic [1:0] SEG_MID  = 2'd1;
    localparam logic [1:0] SEG_HIGH = 2'd2;

    // reciprocal of twice the span, scaled by 2**RECIP_K
    localparam int RECIP_K = 26;
    localparam int RECIP_W = 26;
    localparam int DVD_W   = RECIP_K + 1;
    localparam int CNT_W   = 5;
    localparam int DIV_W   = SAMPLE_W + 1;
    localparam int NUM_W   = 17;
    localparam int RISE_W  = SAMPLE_W + 1;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int Q_W     = SAMPLE_W + 1;

    typedef struct packed {
        logic signed [RISE_W-1:0] rise;
        logic [NUM_W-1:0]         offset;
        logic [RECIP_W-1:0]       recip;
    } plcs_seg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]        r1;
        logic [SAMPLE_W-1:0]        r2;
        plcs_seg_t [SEG_CNT-1:0]    seg;
    } plcs_coef_t;

    typedef struct packed {
        logic en_a;
        logic en_b;
    } plcs_ctrl_t;

endpackage

FILE: sv/piecewise_linear_contrast_stretch.sv
// Three-segment contrast stretch of a pixel stream: each 8-bit component goes through the
// curve (0,0)-(r1,s1)-(r2,s2)-(255,255), rounded half up, with three lanes working on the
// three components side by side. One pixel is taken and one is delivered every clock while the
// divider is idle and m_tready is high; an accepted request passes valid_a_reg and valid_b_reg
// before m_tvalid_reg raises m_tvalid. The segment reciprocals come from a shared bit-serial
// divider: after reset and after every register write, s_tready stays low while it works out
// the three segments in turn. In grey mode (colour_mode 0) only component zero is mapped and
// the others pass unchanged.
module piecewise_linear_contrast_stretch (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [plcs_pkg::TDATA_W-1:0] s_tdata,   // sample_0, sample_1, sample_2
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [plcs_pkg::TDATA_W-1:0] m_tdata,   // mapped_0, mapped_1, mapped_2
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [plcs_pkg::PADDR_W-1:0] paddr,
    input  logic [plcs_pkg::PDATA_W-1:0] pwdata,
    output logic [plcs_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import plcs_pkg::*;

    logic [SAMPLE_W-1:0]  knee_in_low_reg;
    logic [SAMPLE_W-1:0]  knee_out_low_reg;
    logic [SAMPLE_W-1:0]  knee_in_high_reg;
    logic [SAMPLE_W-1:0]  knee_out_high_reg;
    logic                 colour_mode_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    plcs_coef_t           coef;
    logic                 busy;
    plcs_ctrl_t           ctrl;

    logic [SAMPLE_W-1:0]  lane_mapped [NUM_LANES];
    logic [SAMPLE_W-1:0]  lane_raw    [NUM_LANES];

    logic                 valid_a_reg;
    logic                 valid_b_reg;
    logic                 m_tvalid_reg;
    logic [TDATA_W-1:0]   m_tdata_reg;
    logic [TDATA_W-1:0]   m_tdata_next;
    logic                 ready_out;
    logic                 ready_b;
    logic                 ready_a;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            knee_in_low_reg   <= KNEE_IN_LOW_RST;
            knee_out_low_reg  <= KNEE_OUT_LOW_RST;
            knee_in_high_reg  <= KNEE_IN_HIGH_RST;
            knee_out_high_reg <= KNEE_OUT_HIGH_RST;
            colour_mode_reg   <= COLOUR_MODE_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_KNEE_IN_LOW:   knee_in_low_reg   <= pwdata[SAMPLE_W-1:0];
                REG_KNEE_OUT_LOW:  knee_out_low_reg  <= pwdata[SAMPLE_W-1:0];
                REG_KNEE_IN_HIGH:  knee_in_high_reg  <= pwdata[SAMPLE_W-1:0];
                REG_KNEE_OUT_HIGH: knee_out_high_reg <= pwdata[SAMPLE_W-1:0];
                REG_COLOUR_MODE:   colour_mode_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KNEE_IN_LOW:   prdata = PDATA_W'(knee_in_low_reg);
            REG_KNEE_OUT_LOW:  prdata = PDATA_W'(knee_out_low_reg);
            REG_KNEE_IN_HIGH:  prdata = PDATA_W'(knee_in_high_reg);
            REG_KNEE_OUT_HIGH: prdata = PDATA_W'(knee_out_high_reg);
            REG_COLOUR_MODE:   prdata = PDATA_W'(colour_mode_reg);
            default:           prdata = '0;
        endcase
    end

    plcs_coef u_coef (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .restart       (cfg_wr),
        .knee_in_low   (knee_in_low_reg),
        .knee_out_low  (knee_out_low_reg),
        .knee_in_high  (knee_in_high_reg),
        .knee_out_high (knee_out_high_reg),
        .coef          (coef),
        .busy          (busy)
    );

    assign ready_out = !m_tvalid_reg || m_tready;
    assign ready_b   = !valid_b_reg || ready_out;
    assign ready_a   = !valid_a_reg || ready_b;
    assign s_tready  = !busy && ready_a;
    assign ctrl.en_a = ready_a;
    assign ctrl.en_b = ready_b;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        plcs_lane u_lane (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .coef       (coef),
            .sample     (s_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .mapped     (lane_mapped[g]),
            .sample_dly (lane_raw[g])
        );
    end

    // merge lanes, grey mode passes components one and two through
    always_comb begin
        m_tdata_next[SAMPLE_W-1:0] = lane_mapped[0];
        for (int i = 1; i < NUM_LANES; i++) begin
            m_tdata_next[i*SAMPLE_W +: SAMPLE_W] = colour_mode_reg ? lane_mapped[i]
                                                                   : lane_raw[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg  <= 1'b0;
            valid_b_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (ready_a) begin
                valid_a_reg <= s_tvalid && s_tready;
            end
            if (ready_b) begin
                valid_b_reg <= valid_a_reg;
            end
            if (ready_out) begin
                m_tvalid_reg <= valid_b_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_out) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: sv/plcs_coef.sv
module plcs_coef (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          restart,
    input  logic [plcs_pkg::SAMPLE_W-1:0] knee_in_low,
    input  logic [plcs_pkg::SAMPLE_W-1:0] knee_out_low,
    input  logic [plcs_pkg::SAMPLE_W-1:0] knee_in_high,
    input  logic [plcs_pkg::SAMPLE_W-1:0] knee_out_high,
    output plcs_pkg::plcs_coef_t          coef,
    output logic                          busy
);
    import plcs_pkg::*;

    logic                        busy_reg;
    logic [1:0]                  seg_idx_reg;
    logic [CNT_W-1:0]            bit_reg;
    logic [DIV_W-1:0]            rem_reg;
    logic [RECIP_W-1:0]          quo_reg;
    plcs_seg_t [SEG_CNT-1:0]     segs_reg;

    logic [SAMPLE_W-1:0]         span;
    logic [SAMPLE_W-1:0]         base;
    logic signed [RISE_W-1:0]    rise;
    logic [2*SAMPLE_W-1:0]       base_span;
    logic [NUM_W-1:0]            offset_next;
    logic [DIV_W-1:0]            divisor;
    logic [DVD_W-1:0]            dividend;
    logic [DIV_W:0]              trial;
    logic                        fits;
    logic [DIV_W-1:0]            rem_next;
    logic [RECIP_W-1:0]          quo_next;
    logic                        seg_done;

    always_comb begin
        unique case (seg_idx_reg)
            SEG_LOW: begin
                span = knee_in_low;
                base = '0;
                rise = $signed({1'b0, knee_out_low});
            end
            SEG_MID: begin
                span = knee_in_high - knee_in_low;
                base = knee_out_low;
                rise = $signed({1'b0, knee_out_high}) - $signed({1'b0, knee_out_low});
            end
            SEG_HIGH: begin
                span = FULL_SCALE - knee_in_high;
                base = knee_out_high;
                rise = $signed({1'b0, FULL_SCALE}) - $signed({1'b0, knee_out_high});
            end
            default: begin
                span = '0;
                base = '0;
                rise = '0;
            end
        endcase
    end

    assign base_span   = base * span;
    assign offset_next = {base_span, 1'b0} + NUM_W'(span);
    assign divisor     = {span, 1'b0};
    // ceiling of 2**k over the divisor
    assign dividend    = {1'b1, {RECIP_K{1'b0}}} + DVD_W'(divisor) - DVD_W'(1);
    assign trial       = {rem_reg, dividend[bit_reg]};
    assign fits        = trial >= {1'b0, divisor};
    assign rem_next    = fits ? DIV_W'(trial - {1'b0, divisor}) : DIV_W'(trial);
    assign quo_next    = {quo_reg[RECIP_W-2:0], fits};
    assign seg_done    = busy_reg && !restart && (bit_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b1;
            seg_idx_reg <= SEG_LOW;
            bit_reg     <= CNT_W'(DVD_W - 1);
            rem_reg     <= '0;
        end else if (restart) begin
            busy_reg    <= 1'b1;
            seg_idx_reg <= SEG_LOW;
            bit_reg     <= CNT_W'(DVD_W - 1);
            rem_reg     <= '0;
        end else if (busy_reg) begin
            if (bit_reg == '0) begin
                rem_reg <= '0;
                bit_reg <= CNT_W'(DVD_W - 1);
                if (seg_idx_reg == SEG_HIGH) begin
                    busy_reg <= 1'b0;
                end else begin
                    seg_idx_reg <= seg_idx_reg + 2'd1;
                end
            end else begin
                rem_reg <= rem_next;
                bit_reg <= bit_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        if (seg_done) begin
            segs_reg[seg_idx_reg] <= '{rise: rise, offset: offset_next, recip: quo_next};
        end
    end

    assign coef.r1  = knee_in_low;
    assign coef.r2  = knee_in_high;
    assign coef.seg = segs_reg;
    assign busy     = busy_reg;

endmodule

FILE: sv/plcs_lane.sv
module plcs_lane (
    input  logic                          aclk,
    input  plcs_pkg::plcs_ctrl_t          ctrl,
    input  plcs_pkg::plcs_coef_t          coef,
    input  logic [plcs_pkg::SAMPLE_W-1:0] sample,
    output logic [plcs_pkg::SAMPLE_W-1:0] mapped,
    output logic [plcs_pkg::SAMPLE_W-1:0] sample_dly
);
    import plcs_pkg::*;

    plcs_seg_t                 sel;
    logic [SAMPLE_W-1:0]       run;
    logic signed [2*RISE_W-1:0] prod;
    logic [NUM_W-1:0]          num_next;
    logic                      zero_next;

    logic [NUM_W-1:0]          num_reg;
    logic [RECIP_W-1:0]        recip_reg;
    logic                      zero_a_reg;
    logic [SAMPLE_W-1:0]       x_a_reg;

    logic [PROD_W-1:0]         full;
    logic [Q_W-1:0]            q_reg;
    logic                      zero_b_reg;
    logic [SAMPLE_W-1:0]       x_b_reg;

    always_comb begin
        priority if (sample <= coef.r1) begin
            sel = coef.seg[SEG_LOW];
            run = sample;
        end else if (sample <= coef.r2) begin
            sel = coef.seg[SEG_MID];
            run = sample - coef.r1;
        end else begin
            sel = coef.seg[SEG_HIGH];
            run = sample - coef.r2;
        end
    end

    // zero first knee at a zero sample
    assign zero_next = (coef.r1 == '0) && (sample == '0);
    assign prod      = sel.rise * $signed({1'b0, run});
    assign num_next  = sel.offset + {prod[NUM_W-2:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (ctrl.en_a) begin
            num_reg    <= num_next;
            recip_reg  <= sel.recip;
            zero_a_reg <= zero_next;
            x_a_reg    <= sample;
        end
    end

    assign full = num_reg * recip_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.en_b) begin
            q_reg      <= full[RECIP_K+Q_W-1:RECIP_K];
            zero_b_reg <= zero_a_reg;
            x_b_reg    <= x_a_reg;
        end
    end

    always_comb begin
        priority if (zero_b_reg) begin
            mapped = '0;
        end else if (q_reg[Q_W-1]) begin
            mapped = FULL_SCALE;
        end else begin
            mapped = q_reg[SAMPLE_W-1:0];
        end
    end

    assign sample_dly = x_b_reg;

endmodule

FILE: sv/plcs_checker.sv
module plcs_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [plcs_pkg::TDATA_W-1:0] m_tdata,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite
);
    import plcs_pkg::*;

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // coefficients are rebuilt after reset
    a_rst_busy: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_tready)
        else $error("request taken before coefficients are ready");

    a_rst_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result offered right after reset");

    // a register write restarts the coefficient build
    a_cfg_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite |=> !s_tready)
        else $error("request taken right after a register write");

endmodule

bind piecewise_linear_contrast_stretch plcs_checker u_plcs_checker (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import plcs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PIPE_SLACK   = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int RAND_PHASES  = 11;
    localparam int PHASE_PIXELS = 160;
    localparam int LAST_PIXELS  = 166;

    // register slots past the last real one, writes there must be ignored
    localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] c2;
        logic [SAMPLE_W-1:0] c1;
        logic [SAMPLE_W-1:0] c0;
    } pixel_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] in_low;
        logic [SAMPLE_W-1:0] out_low;
        logic [SAMPLE_W-1:0] in_high;
        logic [SAMPLE_W-1:0] out_high;
        logic                colour;
    } curve_cfg_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [TDATA_W-1:0] s_tdata;   // sample_0, sample_1, sample_2
    logic m_tvalid;
    logic m_tready;
    logic [TDATA_W-1:0] m_tdata;   // mapped_0, mapped_1, mapped_2
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    // shadow copy of the curve registers
    logic [SAMPLE_W-1:0] cur_in_low;
    logic [SAMPLE_W-1:0] cur_out_low;
    logic [SAMPLE_W-1:0] cur_in_high;
    logic [SAMPLE_W-1:0] cur_out_high;
    logic                cur_colour;

    pixel_t expected_pixels[$];
    int     error_count    = 0;
    int     report_count   = 0;
    int     pixels_sent    = 0;
    int     pixels_checked = 0;
    int     curve_count    = 0;
    int     write_count    = 0;
    int     cycle_count    = 0;
    int     stall_left     = 0;
    bit     idle_on        = 1'b0;

    piecewise_linear_contrast_stretch uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d requests still pending",
                     cycle_count, expected_pixels.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [SAMPLE_W-1:0] segment_level(longint base, longint rise,
                                                          longint run, longint span);
        longint num;
        longint q;
        num = base * span + rise * run;
        if (num < 0) num = 0;
        q = (2 * num + span) / (2 * span);
        if (q > 255) q = 255;
        return SAMPLE_W'(q);
    endfunction

    function automatic logic [SAMPLE_W-1:0] curve_point(logic [SAMPLE_W-1:0] x);
        longint r1;
        longint s1;
        longint r2;
        longint s2;
        longint v;
        r1 = cur_in_low;
        s1 = cur_out_low;
        r2 = cur_in_high;
        s2 = cur_out_high;
        v  = x;
        if (v <= r1) begin
            if (r1 == 0) return '0;
            return segment_level(0, s1, v, r1);
        end
        if (v <= r2) return segment_level(s1, s2 - s1, v - r1, r2 - r1);
        return segment_level(s2, 255 - s2, v - r2, 255 - r2);
    endfunction

    function automatic pixel_t stretch_pixel(pixel_t px);
        pixel_t res;
        res.c0 = curve_point(px.c0);
        res.c1 = cur_colour ? curve_point(px.c1) : px.c1;
        res.c2 = cur_colour ? curve_point(px.c2) : px.c2;
        return res;
    endfunction

    task automatic note_error(input string what, input int want, input int got);
        error_count++;
        if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    // result checker
    always @(posedge aclk) begin : check_results
        pixel_t got;
        pixel_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got = m_tdata;
            if (expected_pixels.size() == 0) begin
                note_error("unexpected result, pixel", 0, int'(got));
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (got.c0 !== want.c0) note_error("mapped_0", want.c0, got.c0);
                if (got.c1 !== want.c1) note_error("mapped_1", want.c1, got.c1);
                if (got.c2 !== want.c2) note_error("mapped_2", want.c2, got.c2);
            end
        end
    end

    // result side stalls
    always @(negedge aclk) begin
        if (!idle_on) begin
            stall_left = 0;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_pixel(input pixel_t px);
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (s_tready !== 1'b1);
        expected_pixels.insert(expected_pixels.size(), stretch_pixel(px));
        pixels_sent++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (PIPE_SLACK) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        write_count++;
        case (idx)
            REG_KNEE_IN_LOW:   cur_in_low   = value[SAMPLE_W-1:0];
            REG_KNEE_OUT_LOW:  cur_out_low  = value[SAMPLE_W-1:0];
            REG_KNEE_IN_HIGH:  cur_in_high  = value[SAMPLE_W-1:0];
            REG_KNEE_OUT_HIGH: cur_out_high = value[SAMPLE_W-1:0];
            REG_COLOUR_MODE:   cur_colour   = value[0];
            default: ;
        endcase
    endtask

    task automatic apb_read_check(input logic [REG_IDX_W-1:0] idx,
                                  input logic [PDATA_W-1:0] want);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata !== want) note_error($sformatf("register %0d readback", idx), want, prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_registers();
        apb_read_check(REG_KNEE_IN_LOW,   PDATA_W'(cur_in_low));
        apb_read_check(REG_KNEE_OUT_LOW,  PDATA_W'(cur_out_low));
        apb_read_check(REG_KNEE_IN_HIGH,  PDATA_W'(cur_in_high));
        apb_read_check(REG_KNEE_OUT_HIGH, PDATA_W'(cur_out_high));
        apb_read_check(REG_COLOUR_MODE,   PDATA_W'(cur_colour));
    endtask

    task automatic program_curve(input curve_cfg_t cfg);
        wait_idle();
        apb_write(REG_KNEE_IN_LOW,   PDATA_W'(cfg.in_low));
        apb_write(REG_KNEE_OUT_LOW,  PDATA_W'(cfg.out_low));
        apb_write(REG_KNEE_IN_HIGH,  PDATA_W'(cfg.in_high));
        apb_write(REG_KNEE_OUT_HIGH, PDATA_W'(cfg.out_high));
        apb_write(REG_COLOUR_MODE,   PDATA_W'(cfg.colour));
        check_registers();
        curve_count++;
    endtask

    // half knee neighborhoods and end points, the other half uniform
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0: return cur_in_low;
            1: return cur_in_low + 8'd1;
            2: return cur_in_high;
            3: return cur_in_high + 8'd1;
            4: return '0;
            5: return FULL_SCALE;
            default: return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_knee();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return FULL_SCALE;
            default: return SAMPLE_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_pixels(input int count);
        pixel_t px;
        repeat (count) begin
            px.c0 = pick_sample();
            px.c1 = pick_sample();
            px.c2 = pick_sample();
            send_pixel(px);
        end
    endtask

    task automatic test_reset_curve();
        idle_on = 1'b1;
        // fields listed as c2, c1, c0
        send_pixel('{8'h00, 8'hff, 8'h40});
        send_pixel('{8'h41, 8'hc0, 8'hc1});
        send_pixel('{8'haa, 8'h55, 8'h00});
        send_pixel('{8'h55, 8'haa, 8'hff});
        send_pixel('{8'h7f, 8'h80, 8'h01});
        send_pixel('{8'hfe, 8'h3f, 8'hbf});
        wait_idle();
        check_registers();
    endtask

    task automatic test_zero_first_knee();
        program_curve('{in_low: 8'd0, out_low: 8'd200, in_high: 8'd100, out_high: 8'd50,
                        colour: 1'b1});
        send_pixel('{8'h00, 8'h01, 8'h00});
        send_pixel('{8'h64, 8'h65, 8'h00});
        send_pixel('{8'hff, 8'h32, 8'h01});
        send_pixel('{8'h00, 8'h00, 8'hff});
    endtask

    task automatic test_crossed_knees();
        program_curve('{in_low: 8'd200, out_low: 8'd30, in_high: 8'd50, out_high: 8'd220,
                        colour: 1'b1});
        send_pixel('{8'hc8, 8'hc9, 8'h32});
        send_pixel('{8'h33, 8'h00, 8'hff});
        send_pixel('{8'h80, 8'hc7, 8'h31});
        send_pixel('{8'hfe, 8'h01, 8'hca});
    endtask

    task automatic test_top_knee_descending();
        program_curve('{in_low: 8'd10, out_low: 8'd250, in_high: 8'd255, out_high: 8'd5,
                        colour: 1'b1});
        send_pixel('{8'h0a, 8'h0b, 8'hff});
        send_pixel('{8'hfe, 8'h00, 8'h80});
        send_pixel('{8'h09, 8'h85, 8'h86});
        send_pixel('{8'h01, 8'hf0, 8'h0a});
    endtask

    task automatic test_grey_mode();
        program_curve('{in_low: 8'd80, out_low: 8'd20, in_high: 8'd160, out_high: 8'd240,
                        colour: 1'b0});
        send_pixel('{8'hff, 8'h00, 8'h50});
        send_pixel('{8'h00, 8'hff, 8'ha0});
        send_pixel('{8'haa, 8'h55, 8'hff});
        send_pixel('{8'h55, 8'haa, 8'h00});
    endtask

    task automatic test_spare_registers();
        wait_idle();
        apb_write(REG_SPARE_FIRST, 32'hffff_ffff);
        apb_write(REG_SPARE_LAST,  32'h0000_00a5);
        check_registers();
        send_pixel('{8'h5a, 8'h51, 8'hf0});
        send_pixel('{8'ha5, 8'h9f, 8'h0f});
    endtask

    task automatic test_random_curves();
        curve_cfg_t cfg;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0) begin
                cfg = '{in_low: 8'd0, out_low: 8'd0, in_high: 8'd0, out_high: 8'd0,
                        colour: 1'b1};
            end else if (ph == 1) begin
                cfg = '{in_low: 8'd255, out_low: 8'd255, in_high: 8'd255, out_high: 8'd255,
                        colour: 1'b1};
            end else begin
                cfg.in_low   = pick_knee();
                cfg.out_low  = pick_knee();
                cfg.in_high  = pick_knee();
                cfg.out_high = pick_knee();
                cfg.colour   = ($urandom_range(0, 3) != 0);
            end
            // some phases run without stalls on either side
            idle_on = ($urandom_range(0, 3) != 0);
            program_curve(cfg);
            send_random_pixels(PHASE_PIXELS);
        end
    endtask

    task automatic test_full_rate();
        curve_cfg_t cfg;
        cfg.in_low   = pick_knee();
        cfg.out_low  = pick_knee();
        cfg.in_high  = pick_knee();
        cfg.out_high = pick_knee();
        cfg.colour   = 1'b1;
        idle_on = 1'b0;
        program_curve(cfg);
        send_random_pixels(LAST_PIXELS);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cur_in_low   = KNEE_IN_LOW_RST;
        cur_out_low  = KNEE_OUT_LOW_RST;
        cur_in_high  = KNEE_IN_HIGH_RST;
        cur_out_high = KNEE_OUT_HIGH_RST;
        cur_colour   = COLOUR_MODE_RST;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_curve();
        test_zero_first_knee();
        test_crossed_knees();
        test_top_knee_descending();
        test_grey_mode();
        test_spare_registers();
        test_random_curves();
        test_full_rate();
        wait_idle();

        $display("stretched %0d pixels, %0d checked, over %0d curve settings",
                 pixels_sent, pixels_checked, curve_count + 1);
        $display("%0d register writes, %0d errors", write_count, error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
